// ===== design/vgl_pkg.sv =====
package vgl_pkg;

    localparam int GRID_RES_DEF     = 8;
    localparam int BUCKET_DEPTH_DEF = 16;

    localparam int COORD_W = 32;
    localparam int ID_W    = 16;
    localparam int FRAC_W  = 16;
    localparam int TOL_W   = 31;
    localparam int CFG_IDX_W = 4;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 4'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic signed [COORD_W-1:0] offset_z;
        logic [COORD_W-1:0]        scale_x;
        logic [COORD_W-1:0]        scale_y;
        logic [COORD_W-1:0]        scale_z;
        logic [FRAC_W-1:0]         cell_margin;
        logic [TOL_W-1:0]          match_tolerance;
    } cfg_t;

endpackage

// ===== design/vgl_ram.sv =====
module vgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/vgl_queue.sv =====
module vgl_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/vgl_front.sv =====
module vgl_front
    import vgl_pkg::*;
#(
    parameter int GRID_RES = GRID_RES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [ID_W-1:0]           vertex_id,
    input  cfg_t                      cfg,
    input  logic                      hold,
    input  logic                      q_full,
    output logic                      busy,
    output logic                      push,
    output logic [2+ID_W+3*COORD_W+$clog2(GRID_RES**3)+7-1:0] cmd
);

    localparam int CW      = $clog2(GRID_RES);
    localparam int POS_W   = FRAC_W + CW;
    localparam int CELLS   = GRID_RES * GRID_RES * GRID_RES;
    localparam int CIDX_W  = $clog2(CELLS);
    localparam longint POS_MAX = longint'(GRID_RES) * 65536 - 1;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_MUL  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [1:0]                func_reg;
    logic [1:0]                func_next;
    logic signed [COORD_W-1:0] coord_reg [3];
    logic [ID_W-1:0]           id_reg;
    logic [1:0]                axis_reg;
    logic [1:0]                axis_next;
    logic [63:0]               prod_reg;
    logic [63:0]               prod_next;
    logic                      zero_reg;
    logic                      zero_next;
    logic [POS_W-1:0]          pos_reg [3];
    logic [POS_W-1:0]          sat_pos;
    logic                      accept;

    logic signed [COORD_W-1:0] sel_off;
    logic [COORD_W-1:0]        sel_scale;
    logic signed [COORD_W:0]   diff;
    logic [47:0]               prod_hi;

    logic [CW-1:0]             cell_c [3];
    logic [FRAC_W-1:0]         frac_f [3];
    logic [2:0]                lower;
    logic [2:0]                upper;
    logic [CIDX_W-1:0]         home;
    logic [6:0]                mask;

    assign accept = start && !busy;
    assign busy   = (state_reg != FS_IDLE) || hold;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                sel_off   = cfg.offset_x;
                sel_scale = cfg.scale_x;
            end
            2'd1:
            begin
                sel_off   = cfg.offset_y;
                sel_scale = cfg.scale_y;
            end
            default:
            begin
                sel_off   = cfg.offset_z;
                sel_scale = cfg.scale_z;
            end
        endcase
        diff    = {coord_reg[axis_reg][COORD_W-1], coord_reg[axis_reg]} -
                  {sel_off[COORD_W-1], sel_off};
        prod_hi = prod_reg[63:16];
        if (zero_reg)
        begin
            sat_pos = '0;
        end
        else if (prod_hi > 48'(POS_MAX))
        begin
            sat_pos = POS_W'(POS_MAX);
        end
        else
        begin
            sat_pos = prod_hi[POS_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        axis_next  = axis_reg;
        prod_next  = prod_reg;
        zero_next  = zero_reg;
        push       = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    axis_next  = 2'd0;
                    state_next = FS_MUL;
                end
            end
            FS_MUL:
            begin
                // one axis product per cycle, each saturated in the cycle after it is formed
                zero_next = diff[COORD_W] || (diff == '0);
                prod_next = 64'(diff[COORD_W-1:0]) * 64'(sel_scale);
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd3)
                begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cell_c[a] = pos_reg[a][POS_W-1:FRAC_W];
            frac_f[a] = pos_reg[a][FRAC_W-1:0];
            lower[a]  = (cell_c[a] != '0) && (frac_f[a] < cfg.cell_margin);
            upper[a]  = (cell_c[a] != CW'(GRID_RES - 1)) &&
                        (({1'b0, frac_f[a]} + {1'b0, cfg.cell_margin}) > 17'h10000);
        end
        home = (CIDX_W'(cell_c[0]) * CIDX_W'(GRID_RES) + CIDX_W'(cell_c[1])) *
               CIDX_W'(GRID_RES) + CIDX_W'(cell_c[2]);
        unique case (func_reg)
            FUNC_INSERT: mask = {upper[2], lower[2], upper[1], lower[1],
                                 upper[0], lower[0], 1'b1};
            FUNC_LOOKUP: mask = 7'b0000001;
            default:     mask = 7'b0000000;
        endcase
        cmd = {func_reg, id_reg, coord_reg[0], coord_reg[1], coord_reg[2], home, mask};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg[0] <= coord_x;
            coord_reg[1] <= coord_y;
            coord_reg[2] <= coord_z;
            id_reg       <= vertex_id;
        end
        if (state_reg == FS_MUL && axis_reg != 2'd0)
        begin
            pos_reg[axis_reg - 2'd1] <= sat_pos;
        end
        prod_reg <= prod_next;
        zero_reg <= zero_next;
        func_reg <= func_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// ===== design/vgl_back.sv =====
module vgl_back
    import vgl_pkg::*;
#(
    parameter int GRID_RES     = GRID_RES_DEF,
    parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  logic [2+ID_W+3*COORD_W+$clog2(GRID_RES**3)+7-1:0] q_data,
    input  logic [TOL_W-1:0]   tolerance,
    output logic               pop,
    output logic               init_busy,
    output logic               done,
    output logic               found,
    output logic [ID_W-1:0]    match_id,
    output logic               overflow
);

    localparam int CELLS   = GRID_RES * GRID_RES * GRID_RES;
    localparam int CIDX_W  = $clog2(CELLS);
    localparam int SLOTS   = CELLS * BUCKET_DEPTH;
    localparam int SADDR_W = $clog2(SLOTS);
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W  = ID_W + 3 * COORD_W;
    localparam int PLANE   = GRID_RES * GRID_RES;

    localparam logic [2:0] BS_INIT  = 3'd0;
    localparam logic [2:0] BS_IDLE  = 3'd1;
    localparam logic [2:0] BS_CLR   = 3'd2;
    localparam logic [2:0] BS_SEL   = 3'd3;
    localparam logic [2:0] BS_FWAIT = 3'd4;
    localparam logic [2:0] BS_SCAN  = 3'd5;
    localparam logic [2:0] BS_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CIDX_W-1:0]   clr_reg, clr_next;
    logic [1:0]          func_reg, func_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [COORD_W-1:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CIDX_W-1:0]   home_reg, home_next;
    logic [6:0]          mask_reg, mask_next;
    logic [6:0]          bit_reg, bit_next;
    logic [CIDX_W-1:0]   cell_reg, cell_next;
    logic [FILL_W-1:0]   n_reg, n_next;
    logic [FILL_W-1:0]   k_reg, k_next;
    logic                found_reg, found_next;
    logic [ID_W-1:0]     match_reg, match_next;
    logic                ov_reg, ov_next;
    logic                done_reg, done_next;

    logic [CIDX_W-1:0]   tgt_cell;
    logic [6:0]          tgt_bit;
    logic                fill_we;
    logic [CIDX_W-1:0]   fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;
    logic [FILL_W-1:0]   fill_rdata;
    logic                slot_we;
    logic [SADDR_W-1:0]  slot_base;
    logic [SADDR_W-1:0]  slot_raddr;
    logic [SLOT_W-1:0]   slot_rdata;
    logic [ID_W-1:0]     s_id;
    logic [COORD_W-1:0]  s_x, s_y, s_z;
    logic                hit;

    function automatic logic near(input logic [COORD_W-1:0] a,
                                  input logic [COORD_W-1:0] b,
                                  input logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] dv;
        logic [COORD_W:0]        mag;
        dv  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        mag = dv[COORD_W] ? -dv : dv;
        return mag <= (COORD_W + 1)'(tol);
    endfunction

    assign {s_id, s_x, s_y, s_z} = slot_rdata;
    assign slot_base = SADDR_W'(cell_reg) * SADDR_W'(BUCKET_DEPTH);
    assign slot_raddr = (state_reg == BS_FWAIT) ? slot_base :
                        slot_base + SADDR_W'(k_reg) + SADDR_W'(1);

    // lowest pending target: home, x-1, x+1, y-1, y+1, z-1, z+1
    always_comb
    begin
        priority if (mask_reg[0])
        begin
            tgt_cell = home_reg;
            tgt_bit  = 7'b0000001;
        end
        else if (mask_reg[1])
        begin
            tgt_cell = home_reg - CIDX_W'(PLANE);
            tgt_bit  = 7'b0000010;
        end
        else if (mask_reg[2])
        begin
            tgt_cell = home_reg + CIDX_W'(PLANE);
            tgt_bit  = 7'b0000100;
        end
        else if (mask_reg[3])
        begin
            tgt_cell = home_reg - CIDX_W'(GRID_RES);
            tgt_bit  = 7'b0001000;
        end
        else if (mask_reg[4])
        begin
            tgt_cell = home_reg + CIDX_W'(GRID_RES);
            tgt_bit  = 7'b0010000;
        end
        else if (mask_reg[5])
        begin
            tgt_cell = home_reg - CIDX_W'(1);
            tgt_bit  = 7'b0100000;
        end
        else
        begin
            tgt_cell = home_reg + CIDX_W'(1);
            tgt_bit  = 7'b1000000;
        end
    end

    always_comb
    begin
        if (func_reg == FUNC_INSERT)
        begin
            hit = (s_id == id_reg);
        end
        else
        begin
            hit = near(s_x, x_reg, tolerance) && near(s_y, y_reg, tolerance) &&
                  near(s_z, z_reg, tolerance);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        func_next  = func_reg;
        id_next    = id_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        home_next  = home_reg;
        mask_next  = mask_reg;
        bit_next   = bit_reg;
        cell_next  = cell_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        found_next = found_reg;
        match_next = match_reg;
        ov_next    = ov_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        fill_we    = 1'b0;
        fill_waddr = clr_reg;
        fill_wdata = '0;
        slot_we    = 1'b0;
        unique case (state_reg)
            BS_INIT, BS_CLR:
            begin
                fill_we  = 1'b1;
                clr_next = clr_reg + CIDX_W'(1);
                if (clr_reg == CIDX_W'(CELLS - 1))
                begin
                    state_next = (state_reg == BS_INIT) ? BS_IDLE : BS_DONE;
                end
            end
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    {func_next, id_next, x_next, y_next, z_next, home_next,
                        mask_next} = q_data;
                    found_next = 1'b0;
                    match_next = '0;
                    ov_next    = 1'b0;
                    clr_next   = '0;
                    unique case (q_data[$bits(q_data)-1 -: 2])
                        FUNC_CLEAR:  state_next = BS_CLR;
                        FUNC_INSERT: state_next = BS_SEL;
                        FUNC_LOOKUP: state_next = BS_SEL;
                        default:     state_next = BS_DONE;
                    endcase
                end
            end
            BS_SEL:
            begin
                if (mask_reg == '0)
                begin
                    state_next = BS_DONE;
                end
                else
                begin
                    cell_next  = tgt_cell;
                    bit_next   = tgt_bit;
                    state_next = BS_FWAIT;
                end
            end
            BS_FWAIT:
            begin
                n_next     = fill_rdata;
                k_next     = '0;
                state_next = BS_SCAN;
            end
            BS_SCAN:
            begin
                if (k_reg < n_reg)
                begin
                    if (hit)
                    begin
                        if (func_reg == FUNC_INSERT)
                        begin
                            mask_next  = mask_reg & ~bit_reg;
                            state_next = BS_SEL;
                        end
                        else
                        begin
                            found_next = 1'b1;
                            match_next = s_id;
                            state_next = BS_DONE;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + FILL_W'(1);
                    end
                end
                else if (func_reg == FUNC_INSERT)
                begin
                    if (n_reg >= FILL_W'(BUCKET_DEPTH))
                    begin
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        fill_we    = 1'b1;
                        fill_waddr = cell_reg;
                        fill_wdata = n_reg + FILL_W'(1);
                    end
                    mask_next  = mask_reg & ~bit_reg;
                    state_next = BS_SEL;
                end
                else
                begin
                    state_next = BS_DONE;
                end
            end
            BS_DONE:
            begin
                done_next  = 1'b1;
                state_next = BS_IDLE;
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    vgl_ram #(
        .WIDTH (FILL_W),
        .DEPTH (CELLS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (tgt_cell),
        .rdata (fill_rdata)
    );

    vgl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_base + SADDR_W'(n_reg)),
        .wdata ({id_reg, x_reg, y_reg, z_reg}),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        home_reg  <= home_next;
        bit_reg   <= bit_next;
        cell_reg  <= cell_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        match_reg <= match_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_INIT;
            clr_reg   <= '0;
            func_reg  <= FUNC_CLEAR;
            mask_reg  <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            func_reg  <= func_next;
            mask_reg  <= mask_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
            done_reg  <= done_next;
        end
    end

    assign init_busy = (state_reg == BS_INIT);
    assign done      = done_reg;
    assign found     = found_reg;
    assign match_id  = match_reg;
    assign overflow  = ov_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_we && state_reg == BS_SCAN) |-> fill_wdata <= FILL_W'(BUCKET_DEPTH))
        else $error("bucket fill beyond depth");

    a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> func_reg == FUNC_LOOKUP)
        else $error("match reported for a non-lookup transaction");

    a_ov_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ov_reg) |-> func_reg == FUNC_INSERT)
        else $error("overflow reported for a non-insert transaction");

endmodule

// ===== design/vertex_grid_lookup_unit.sv =====
// operation: a clear sweeps every cell of the fill memory; a lookup scans the home bucket and an
// insert scans every marked bucket, one stored slot read per cycle from the slot memory
// concurrency: one transaction at a time through the scan; the front takes the next one while
// the back still scans, with up to two queued commands ahead
// reset: after rst_n the cell fill memory is swept with busy high; config takes
// its reset values at once; done strobes for one cycle and the receiver cannot stall
module vertex_grid_lookup_unit
    import vgl_pkg::*;
#(
    parameter int GRID_RES     = GRID_RES_DEF,
    parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [ID_W-1:0]           vertex_id,
    output logic                      done,
    output logic                      found,
    output logic [ID_W-1:0]           match_id,
    output logic                      overflow,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int CMD_W = 2 + ID_W + 3 * COORD_W + $clog2(GRID_RES**3) + 7;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             init_busy;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic [CMD_W-1:0] fe_cmd;
    logic [CMD_W-1:0] q_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X:  cfg_next.offset_x        = cfg_data;
                CFG_OFFSET_Y:  cfg_next.offset_y        = cfg_data;
                CFG_OFFSET_Z:  cfg_next.offset_z        = cfg_data;
                CFG_SCALE_X:   cfg_next.scale_x         = cfg_data;
                CFG_SCALE_Y:   cfg_next.scale_y         = cfg_data;
                CFG_SCALE_Z:   cfg_next.scale_z         = cfg_data;
                CFG_MARGIN:    cfg_next.cell_margin     = cfg_data[FRAC_W-1:0];
                CFG_TOLERANCE: cfg_next.match_tolerance = cfg_data[TOL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x        <= '0;
            cfg_reg.offset_y        <= '0;
            cfg_reg.offset_z        <= '0;
            cfg_reg.scale_x         <= 32'h0001_0000;
            cfg_reg.scale_y         <= 32'h0001_0000;
            cfg_reg.scale_z         <= 32'h0001_0000;
            cfg_reg.cell_margin     <= 16'd13;
            cfg_reg.match_tolerance <= 31'd13;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vgl_front #(
        .GRID_RES (GRID_RES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .vertex_id (vertex_id),
        .cfg       (cfg_reg),
        .hold      (init_busy),
        .q_full    (q_full),
        .busy      (busy),
        .push      (q_push),
        .cmd       (fe_cmd)
    );

    vgl_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (fe_cmd),
        .pop   (q_pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    vgl_back #(
        .GRID_RES     (GRID_RES),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .tolerance (cfg_reg.match_tolerance),
        .pop       (q_pop),
        .init_busy (init_busy),
        .done      (done),
        .found     (found),
        .match_id  (match_id),
        .overflow  (overflow)
    );

endmodule

// ===== tb/vertex_grid_lookup_unit_tb.sv =====
`timescale 1ns / 100ps

module vertex_grid_lookup_unit_tb;
    import vgl_pkg::*;

    localparam int GRID       = 8;
    localparam int DEPTH      = 16;
    localparam int CELLS      = GRID * GRID * GRID;
    localparam int CYCLE_CAP  = 4000000;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] match_id;
        logic            overflow;
    } grid_reply_t;

    typedef struct {
        logic [1:0]        op;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        logic [ID_W-1:0]   id;
        bit                typed;
        grid_reply_t       reply;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] func = FUNC_CLEAR;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic signed [COORD_W-1:0] coord_z = '0;
    logic [ID_W-1:0] vertex_id = '0;
    logic done;
    logic found;
    logic [ID_W-1:0] match_id;
    logic overflow;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vertex_grid_lookup_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .vertex_id(vertex_id),
        .done(done), .found(found), .match_id(match_id), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the grid table and registers
    logic signed [31:0] org_x, org_y, org_z;
    logic [31:0] rcp_x, rcp_y, rcp_z;
    logic [15:0] border;
    logic [30:0] tol;
    int unsigned fill_cnt [CELLS];
    logic [ID_W-1:0] bin_id [CELLS][DEPTH];
    logic [31:0] bin_x [CELLS][DEPTH];
    logic [31:0] bin_y [CELLS][DEPTH];
    logic [31:0] bin_z [CELLS][DEPTH];

    grid_reply_t pending_replies [$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    function automatic logic [31:0] cell_pos(logic [31:0] c, logic signed [31:0] o,
                                             logic [31:0] s);
        longint d;
        logic [63:0] p;
        d = longint'($signed(c)) - longint'(o);
        if (d <= 0) return '0;
        p = (64'(d) * 64'(s)) >> 16;
        if (p > GRID * 65536 - 1) p = GRID * 65536 - 1;
        return p[31:0];
    endfunction

    function automatic bit near(logic [31:0] a, logic [31:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0) d = -d;
        return d <= longint'(tol);
    endfunction

    function automatic bit bin_add(int c, logic [ID_W-1:0] id, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z);
        for (int k = 0; k < fill_cnt[c]; k++)
            if (bin_id[c][k] == id) return 1'b0;
        if (fill_cnt[c] >= DEPTH) return 1'b1;
        bin_id[c][fill_cnt[c]] = id;
        bin_x[c][fill_cnt[c]] = x;
        bin_y[c][fill_cnt[c]] = y;
        bin_z[c][fill_cnt[c]] = z;
        fill_cnt[c]++;
        return 1'b0;
    endfunction

    function automatic grid_reply_t grid_apply(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [ID_W-1:0] id);
        grid_reply_t r;
        logic [31:0] px, py, pz;
        int cx, cy, cz, home;
        bit ov;
        r = '0;
        px = cell_pos(x, org_x, rcp_x);
        py = cell_pos(y, org_y, rcp_y);
        pz = cell_pos(z, org_z, rcp_z);
        cx = px >> 16; cy = py >> 16; cz = pz >> 16;
        home = (cx * GRID + cy) * GRID + cz;
        if (op == FUNC_CLEAR) begin
            foreach (fill_cnt[c]) fill_cnt[c] = 0;
        end else if (op == FUNC_INSERT) begin
            ov = bin_add(home, id, x, y, z);
            if (cx > 0 && px[15:0] < border)
                ov |= bin_add(home - GRID * GRID, id, x, y, z);
            if (cx < GRID - 1 && 32'(px[15:0]) + border > 65536)
                ov |= bin_add(home + GRID * GRID, id, x, y, z);
            if (cy > 0 && py[15:0] < border)
                ov |= bin_add(home - GRID, id, x, y, z);
            if (cy < GRID - 1 && 32'(py[15:0]) + border > 65536)
                ov |= bin_add(home + GRID, id, x, y, z);
            if (cz > 0 && pz[15:0] < border)
                ov |= bin_add(home - 1, id, x, y, z);
            if (cz < GRID - 1 && 32'(pz[15:0]) + border > 65536)
                ov |= bin_add(home + 1, id, x, y, z);
            r.overflow = ov;
        end else if (op == FUNC_LOOKUP) begin
            for (int k = 0; k < fill_cnt[home]; k++)
                if (near(bin_x[home][k], x) && near(bin_y[home][k], y) &&
                    near(bin_z[home][k], z)) begin
                    r.found = 1'b1;
                    r.match_id = bin_id[home][k];
                    break;
                end
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_OFFSET_X:  org_x = val;
            CFG_OFFSET_Y:  org_y = val;
            CFG_OFFSET_Z:  org_z = val;
            CFG_SCALE_X:   rcp_x = val;
            CFG_SCALE_Y:   rcp_y = val;
            CFG_SCALE_Z:   rcp_z = val;
            CFG_MARGIN:    border = val[15:0];
            CFG_TOLERANCE: tol = val[30:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    // drives one transaction; typed rows override the predictor's expectation
    // start stays high after acceptance until the next idle cycle or the end of a phase
    task automatic send_op(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [ID_W-1:0] id, bit typed = 1'b0,
                           grid_reply_t typed_reply = '0);
        grid_reply_t r;
        if (!quiet)
            while ($urandom_range(99) < 14)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        func <= op;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        vertex_id <= id;
        do @(posedge clk); while (busy);
        r = grid_apply(op, x, y, z, id);
        if (typed) begin
            if (r != typed_reply) begin
                $error("predictor disagrees with directed row: %h vs %h", r, typed_reply);
                errors++;
            end
            r = typed_reply;
        end
        pending_replies.push_back(r);
    endtask

    always @(posedge clk)
    begin
        grid_reply_t want;
        if (rst_n && done) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (found !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, found);
                    errors++;
                end
                if (match_id !== want.match_id) begin
                    $error("match_id: expected %0d actual %0d", want.match_id, match_id);
                    errors++;
                end
                if (overflow !== want.overflow) begin
                    $error("overflow: expected %0d actual %0d", want.overflow, overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("vertex_grid_lookup_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return 32'($urandom_range(GRID * 65536 - 1));
        endcase
    endfunction

    task automatic random_phase(int n, int id_span);
        logic [31:0] x, y, z;
        logic [1:0] op;
        int pick;
        for (int i = 0; i < n; i++) begin
            quiet = (i >= n / 3 && i < n / 2);
            pick = $urandom_range(99);
            x = rand_coord(); y = rand_coord(); z = rand_coord();
            if (pick < 2) op = FUNC_CLEAR;
            else if (pick < 45) op = FUNC_INSERT;
            else op = FUNC_LOOKUP;
            // most lookups probe a random point inside the grid range
            if (op == FUNC_LOOKUP && $urandom_range(3) != 0) begin
                x = 32'($urandom_range(GRID * 65536 - 1));
                y = 32'($urandom_range(GRID * 65536 - 1));
                z = 32'($urandom_range(GRID * 65536 - 1));
            end
            send_op(op, x, y, z, 16'($urandom_range(id_span)));
            if (op == FUNC_INSERT && $urandom_range(1))
                send_op(FUNC_LOOKUP, x + $urandom_range(20) - 10, y + $urandom_range(20) - 10,
                        z + $urandom_range(20) - 10, '0);
        end
        quiet = 1'b0;
        start <= 1'b0;
    endtask

    initial
    begin
        probe_row_t rows [$];
        probe_row_t row;
        org_x = 0; org_y = 0; org_z = 0;
        rcp_x = 65536; rcp_y = 65536; rcp_z = 65536;
        border = 13; tol = 13;
        foreach (fill_cnt[c]) fill_cnt[c] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: extremes, every operation, duplicate, overflow, unused code
        rows.push_back('{FUNC_LOOKUP, 0, 0, 0, 0, 1, '{0, 0, 0}});
        rows.push_back('{FUNC_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff,
                         1, '{0, 0, 0}});
        rows.push_back('{FUNC_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                         1, '{1, 16'hffff, 0}});
        rows.push_back('{FUNC_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0001,
                         1, '{0, 0, 0}});
        rows.push_back('{FUNC_LOOKUP, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0,
                         1, '{1, 1, 0}});
        rows.push_back('{FUNC_INSERT, 32'h0001_0005, 32'h0002_fff8, 32'h0003_8000, 7, 0, '0});
        rows.push_back('{FUNC_INSERT, 32'h0001_0005, 32'h0002_fff8, 32'h0003_8000, 7, 0, '0});
        rows.push_back('{FUNC_LOOKUP, 32'h0000_fffe, 32'h0002_fff8, 32'h0003_8000, 0, 0, '0});
        rows.push_back('{FUNC_LOOKUP, 32'h0001_0005, 32'h0002_fff8, 32'h0003_8000, 0, 0, '0});
        rows.push_back('{FUNC_LOOKUP, 32'h0001_0030, 32'h0002_fff8, 32'h0003_8000, 0, 0, '0});
        rows.push_back('{2'd3, 32'h0001_0005, 32'h0002_fff8, 32'h0003_8000, 3, 1, '{0, 0, 0}});
        for (int k = 0; k < DEPTH; k++)
            rows.push_back('{FUNC_INSERT, 32'h0004_8000 + k, 32'h0004_8000, 32'h0004_8000,
                             16'(100 + k), 1, '{0, 0, 0}});
        rows.push_back('{FUNC_INSERT, 32'h0004_8100, 32'h0004_8000, 32'h0004_8000, 16'h5555,
                         1, '{0, 0, 1}});
        rows.push_back('{FUNC_CLEAR, 32'hffff_ffff, 0, 0, 16'haaaa, 1, '{0, 0, 0}});
        rows.push_back('{FUNC_LOOKUP, 32'h0004_8000, 32'h0004_8000, 32'h0004_8000, 0,
                         1, '{0, 0, 0}});
        foreach (rows[i]) begin
            row = rows[i];
            send_op(row.op, row.x, row.y, row.z, row.id, row.typed, row.reply);
        end
        random_phase(500, 40);

        // quarter, zero and maximal scales, wide margin and tolerance
        drain_results();
        write_reg(CFG_OFFSET_X, 32'hfffc_0000);
        write_reg(CFG_OFFSET_Y, 32'h8000_0000);
        write_reg(CFG_OFFSET_Z, 32'h7fff_ffff);
        write_reg(CFG_SCALE_X, 32'h0000_4000);
        write_reg(CFG_SCALE_Y, 32'h0000_0000);
        write_reg(CFG_SCALE_Z, 32'hffff_ffff);
        write_reg(CFG_MARGIN, 32'h0000_ffff);
        write_reg(CFG_TOLERANCE, 32'h7fff_ffff);
        send_op(FUNC_CLEAR, 0, 0, 0, 0);
        random_phase(300, 300);

        // fine grid, zero margin and tolerance
        drain_results();
        write_reg(CFG_OFFSET_X, 0);
        write_reg(CFG_OFFSET_Y, 0);
        write_reg(CFG_OFFSET_Z, 0);
        write_reg(CFG_SCALE_X, 32'h0001_0000);
        write_reg(CFG_SCALE_Y, 32'h0001_0000);
        write_reg(CFG_SCALE_Z, 32'h0001_0000);
        write_reg(CFG_MARGIN, 0);
        write_reg(CFG_TOLERANCE, 0);
        random_phase(300, 65535);

        // mid settings
        drain_results();
        write_reg(CFG_SCALE_Y, 32'h0002_0000);
        write_reg(CFG_MARGIN, 32'h0000_2000);
        write_reg(CFG_TOLERANCE, 32'h0000_0400);
        random_phase(400, 60);

        drain_results();
        if (errors == 0)
            $display("vertex_grid_lookup_unit_tb passed");
        else
            $display("vertex_grid_lookup_unit_tb failed");
        $finish;
    end

endmodule
